[rtl/tvsp_pkg.sv]
package tvsp_pkg;

   localparam int LENGTH_BITS = 32;
   localparam logic [3:0] LEN_BYTES = 4'((LENGTH_BITS + 7) / 8);
   localparam logic [31:0] LEN_MASK = 32'((64'd1 << LENGTH_BITS) - 64'd1);

   localparam logic [3:0] INT_BYTES = 4'd4;
   localparam logic [3:0] DBL_BYTES = 4'd8;

   localparam logic [7:0] TAG_BOOL = 8'h62;
   localparam logic [7:0] TAG_INT = 8'h69;
   localparam logic [7:0] TAG_DBL = 8'h64;
   localparam logic [7:0] TAG_EMPTY_STR = 8'h73;
   localparam logic [7:0] TAG_LONG_STR = 8'h53;
   localparam logic [7:0] SHORT_STR_BASE = 8'h80;
   localparam logic [7:0] CHAR_TRUE = 8'h74;
   localparam logic [7:0] CHAR_FALSE = 8'h66;

   typedef enum logic [5:0] {
      PH_TAG   = 6'b000001,
      PH_BOOL  = 6'b000010,
      PH_INT   = 6'b000100,
      PH_DBL   = 6'b001000,
      PH_SLEN  = 6'b010000,
      PH_SDATA = 6'b100000
   } phase_type;

   typedef enum logic [2:0] {
      EV_BOOL  = 3'd0,
      EV_INT   = 3'd1,
      EV_DBL   = 3'd2,
      EV_HDR   = 3'd3,
      EV_SBYTE = 3'd4,
      EV_END   = 3'd5,
      EV_ERR   = 3'd6
   } event_type;

   typedef enum logic [1:0] {
      ERR_TAG   = 2'd0,
      ERR_BOOL  = 2'd1,
      ERR_TRUNC = 2'd2
   } error_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       end_of_input;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [63:0] value_bits;
      logic [31:0] string_length;
      logic        last_string_byte;
      logic [1:0]  error_code;
   } rsp_item_type;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  byte_count;
      logic [63:0] assembled_value;
      logic [31:0] remaining_string;
   } parse_state_type;

endpackage

[rtl/tvsp_step.sv]
module tvsp_step (
   input  tvsp_pkg::parse_state_type state,
   input  tvsp_pkg::req_item_type    item,
   output tvsp_pkg::parse_state_type state_next,
   output logic                      result_valid,
   output tvsp_pkg::rsp_item_type    result
);
   import tvsp_pkg::*;

   logic [7:0]  b;
   logic [3:0]  count_inc;
   logic [63:0] gathered;
   logic [31:0] rem_dec;
   logic [31:0] long_len;

   assign b = item.byte_value;
   assign count_inc = state.byte_count + 4'd1;
   assign gathered = state.assembled_value
                   | ({56'd0, b} << {state.byte_count[2:0], 3'b000});
   assign rem_dec = (state.remaining_string != 32'd0) ? state.remaining_string - 32'd1
                                                      : state.remaining_string;
   assign long_len = gathered[31:0] & LEN_MASK;

   always_comb begin
      state_next = state;
      result_valid = 1'b0;
      result = '0;
      if (item.end_of_input) begin
         result_valid = 1'b1;
         if (state.phase == PH_TAG) begin
            result.event_kind = EV_END;
         end else begin
            state_next.phase = PH_TAG;
            state_next.byte_count = '0;
            state_next.assembled_value = '0;
            state_next.remaining_string = '0;
            result.event_kind = EV_ERR;
            result.error_code = ERR_TRUNC;
         end
      end else begin
         unique case (state.phase)
            PH_BOOL: begin
               state_next.phase = PH_TAG;
               state_next.byte_count = '0;
               state_next.assembled_value = '0;
               result_valid = 1'b1;
               priority if (b == CHAR_TRUE) begin
                  result.event_kind = EV_BOOL;
                  result.value_bits = 64'd1;
               end else if (b == CHAR_FALSE) begin
                  result.event_kind = EV_BOOL;
               end else begin
                  result.event_kind = EV_ERR;
                  result.error_code = ERR_BOOL;
               end
            end
            PH_INT: begin
               state_next.byte_count = count_inc;
               state_next.assembled_value = gathered;
               if (count_inc >= INT_BYTES) begin
                  state_next.phase = PH_TAG;
                  state_next.byte_count = '0;
                  state_next.assembled_value = '0;
                  result_valid = 1'b1;
                  result.event_kind = EV_INT;
                  result.value_bits = {32'd0, gathered[31:0]};
               end
            end
            PH_DBL: begin
               state_next.byte_count = count_inc;
               state_next.assembled_value = gathered;
               if (count_inc >= DBL_BYTES) begin
                  state_next.phase = PH_TAG;
                  state_next.byte_count = '0;
                  state_next.assembled_value = '0;
                  result_valid = 1'b1;
                  result.event_kind = EV_DBL;
                  result.value_bits = gathered;
               end
            end
            PH_SLEN: begin
               state_next.byte_count = count_inc;
               state_next.assembled_value = gathered;
               if (count_inc >= LEN_BYTES) begin
                  state_next.phase = (long_len != 32'd0) ? PH_SDATA : PH_TAG;
                  state_next.byte_count = '0;
                  state_next.assembled_value = '0;
                  state_next.remaining_string = long_len;
                  result_valid = 1'b1;
                  result.event_kind = EV_HDR;
                  result.string_length = long_len;
               end
            end
            PH_SDATA: begin
               state_next.remaining_string = rem_dec;
               result_valid = 1'b1;
               result.event_kind = EV_SBYTE;
               result.value_bits = {56'd0, b};
               if (rem_dec == 32'd0) begin
                  state_next.phase = PH_TAG;
                  state_next.byte_count = '0;
                  state_next.assembled_value = '0;
                  result.last_string_byte = 1'b1;
               end
            end
            PH_TAG: begin
               state_next.byte_count = '0;
               state_next.assembled_value = '0;
               priority if (b == TAG_BOOL) begin
                  state_next.phase = PH_BOOL;
               end else if (b == TAG_INT) begin
                  state_next.phase = PH_INT;
               end else if (b == TAG_DBL) begin
                  state_next.phase = PH_DBL;
               end else if (b == TAG_EMPTY_STR) begin
                  state_next.remaining_string = '0;
                  result_valid = 1'b1;
                  result.event_kind = EV_HDR;
               end else if (b == TAG_LONG_STR) begin
                  state_next.phase = PH_SLEN;
               end else if (b > SHORT_STR_BASE) begin
                  state_next.phase = PH_SDATA;
                  state_next.remaining_string = {24'd0, b - SHORT_STR_BASE};
                  result_valid = 1'b1;
                  result.event_kind = EV_HDR;
                  result.string_length = {24'd0, b - SHORT_STR_BASE};
               end else begin
                  result_valid = 1'b1;
                  result.event_kind = EV_ERR;
                  result.error_code = ERR_TAG;
               end
            end
            default: begin
               state_next.phase = PH_TAG;
               state_next.byte_count = '0;
               state_next.assembled_value = '0;
            end
         endcase
      end
   end

endmodule

[rtl/tagged_value_stream_parser_core.sv]
// Decodes a tagged serialized byte stream, one byte per req item, into bool, int,
// double, string header, string byte, end and error items on rsp. Each byte is
// captured in an input register, decoded against the parse state and, when it
// produces a result, lands in the output register: one item per cycle sustained
// while rsp is not stalled. Tag, length and number bytes that complete nothing
// produce no rsp item. A stalled rsp holds one result in the output register; the
// input register still takes a byte, which waits there if it yields a result.
module tagged_value_stream_parser_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tvsp_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tvsp_pkg::rsp_item_type rsp_item
);
   import tvsp_pkg::*;

   logic            in_valid_ff, in_valid_in;
   req_item_type    in_item_ff;
   parse_state_type state_ff, state_in;
   logic            out_valid_ff, out_valid_in;
   rsp_item_type    out_item_ff;

   parse_state_type step_state;
   logic            step_valid;
   rsp_item_type    step_result;
   logic            advance;

   tvsp_step u_step (
      .state        (state_ff),
      .item         (in_item_ff),
      .state_next   (step_state),
      .result_valid (step_valid),
      .result       (step_result)
   );

   assign advance = in_valid_ff && (!step_valid || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;
   assign state_in = advance ? step_state : state_ff;

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      if (advance && step_valid) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff.phase <= PH_TAG;
         state_ff.byte_count <= '0;
         state_ff.assembled_value <= '0;
         state_ff.remaining_string <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
      if (advance && step_valid) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item = out_item_ff;

   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff.phase))
      else $error("parse phase not one-hot");

   a_tag_clean: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_TAG |-> state_ff.byte_count == 4'd0
                                   && state_ff.assembled_value == 64'd0)
      else $error("gather state not cleared while awaiting tag");

   a_sdata_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_SDATA |-> state_ff.remaining_string != 32'd0)
      else $error("string payload phase with nothing remaining");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.byte_count < DBL_BYTES)
      else $error("byte count overran element width");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready && in_valid_ff && step_valid |=> in_valid_ff
                                                                  && $stable(state_ff))
      else $error("item advanced into a stalled result register");

endmodule
